FILE: sv/orbo_pkg.sv
package orbo_pkg;

    // Coordinate and register widths
    localparam int COORD_W = 24;
    localparam int TOL_W   = 8;

    // Angle: a power-of-two number of steps per turn, one bit per step index bit
    localparam int ANGLE_W     = 12;
    localparam int ANGLE_STEPS = 2 ** ANGLE_W;
    localparam int QTR_STEPS   = ANGLE_STEPS / 4;
    localparam int QTR_W       = $clog2(QTR_STEPS);

    // Quarter-wave ROM: one entry per quarter-turn step, both ends included
    localparam int ROM_DEPTH = QTR_STEPS + 1;
    localparam int ROM_AW    = $clog2(ROM_DEPTH);

    // Trig magnitude 0..32768 in Q1.15, 32768 meaning exactly 1.0
    localparam int TRIG_W     = 16;
    localparam int TRIG_ONE   = 32768;
    localparam int TRIG_SHIFT = 15;
    localparam int TOL_SHIFT  = 16;

    // Doubled center delta, box extent, and projection widths
    localparam int DELTA_W = COORD_W + 2;
    localparam int EXT_W   = COORD_W + 1;
    localparam int PROJ_W  = 44;

    // Taylor series constants for the table build, Q30
    localparam longint unsigned PI_HALF_Q30  = 64'd1686629713;
    localparam longint          Q30_ONE      = 64'sd1073741824;
    localparam longint          Q15_HALF     = 64'sd16384;
    localparam int              TAYLOR_TERMS = 8;
    localparam longint unsigned TAYLOR_DIV [1:TAYLOR_TERMS] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272};

    typedef logic [TRIG_W-1:0] trig_mag_t;
    typedef trig_mag_t sine_rom_t [ROM_DEPTH];

    // Signed cosine/sine of the current angle and their magnitudes
    typedef struct packed {
        logic signed [TRIG_W:0] c;
        logic signed [TRIG_W:0] s;
        trig_mag_t              abs_c;
        trig_mag_t              abs_s;
    } trig_t;

    // sin(pi/2 * num / ANGLE_STEPS) in Q15, num in 0..ANGLE_STEPS
    function automatic trig_mag_t quarter_sine(input longint unsigned num);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          m;
        int              k;
        x    = (PI_HALF_Q30 * num) / ANGLE_STEPS;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (k = 1; k <= TAYLOR_TERMS; k++)
        begin
            term = (term * x2) >> 30;
            term = term / TAYLOR_DIV[k];
            if ((k & 1) != 0)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > Q30_ONE)
            sum = Q30_ONE;
        m = (sum + Q15_HALF) >>> 15;
        if (m > TRIG_ONE)
            m = TRIG_ONE;
        return TRIG_W'(m);
    endfunction

    // Entry i holds the sine at quarter-turn position 4*i
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        int        i;
        for (i = 0; i < ROM_DEPTH; i++)
        begin
            rom[i] = quarter_sine(longint'(4 * i));
        end
        return rom;
    endfunction

endpackage

FILE: sv/orbo_trig.sv
module orbo_trig
    import orbo_pkg::*;
(
    input  logic               clk,
    input  logic               load,
    input  logic [ANGLE_W-1:0] angle,
    output trig_t              trig
);

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    localparam logic [1:0] QUAD_FIRST  = 2'd0;
    localparam logic [1:0] QUAD_SECOND = 2'd1;
    localparam logic [1:0] QUAD_THIRD  = 2'd2;

    logic [QTR_W-1:0]  step;
    logic [1:0]        quad;
    logic [ROM_AW-1:0] sin_idx;
    logic [ROM_AW-1:0] cos_idx;

    trig_mag_t  ms_reg;
    trig_mag_t  mc_reg;
    logic [1:0] quad_reg;

    logic signed [TRIG_W:0] ms_s;
    logic signed [TRIG_W:0] mc_s;

    // Split the angle into quadrant and step within the quarter turn
    assign step    = angle[QTR_W-1:0];
    assign quad    = angle[QTR_W+1:QTR_W];
    assign sin_idx = ROM_AW'(step);
    assign cos_idx = ROM_AW'(QTR_STEPS) - sin_idx;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ms_reg   <= SINE_ROM[sin_idx];
            mc_reg   <= SINE_ROM[cos_idx];
            quad_reg <= quad;
        end
    end

    assign ms_s = $signed({1'b0, ms_reg});
    assign mc_s = $signed({1'b0, mc_reg});

    always_comb
    begin
        case (quad_reg)
            QUAD_FIRST:
            begin
                trig.c = mc_s;
                trig.s = ms_s;
            end
            QUAD_SECOND:
            begin
                trig.c = -ms_s;
                trig.s = mc_s;
            end
            QUAD_THIRD:
            begin
                trig.c = -mc_s;
                trig.s = -ms_s;
            end
            default:
            begin
                trig.c = ms_s;
                trig.s = -mc_s;
            end
        endcase
        // Odd quadrants swap the magnitudes
        trig.abs_c = quad_reg[0] ? ms_reg : mc_reg;
        trig.abs_s = quad_reg[0] ? mc_reg : ms_reg;
    end

endmodule

FILE: sv/oriented_rect_box_overlap.sv
// Channel   Handshake                Word
// --------  -----------------------  ---------------------------------------------
// input     in_valid / in_ready      rect center, size, angle; box min/max corners
// output    out_valid / out_ready    overlap_hit, used_point_test
// config    cfg_wr_en / cfg_wr_data  touch_tolerance, taken on any enabled edge
//
// One word per cycle sustained while out_ready holds; each result passes through
// the five register stages in turn: ROM read, multiply, partial sums, absolute
// value and final sum, compare into the output register.
// Reset clears the stage valid bits and touch_tolerance; payload holds no reset.
// A stall on the output freezes only the full stages behind it; empty stages
// still fill, so the input keeps taking words until every stage is full.
module oriented_rect_box_overlap
    import orbo_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [TOL_W-1:0]          cfg_wr_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [COORD_W-1:0] rect_center_x,
    input  logic signed [COORD_W-1:0] rect_center_y,
    input  logic signed [COORD_W-1:0] rect_size_x,
    input  logic signed [COORD_W-1:0] rect_size_y,
    input  logic [ANGLE_W-1:0]        rect_angle,
    input  logic signed [COORD_W-1:0] box_min_x,
    input  logic signed [COORD_W-1:0] box_min_y,
    input  logic signed [COORD_W-1:0] box_max_x,
    input  logic signed [COORD_W-1:0] box_max_y,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      overlap_hit,
    output logic                      used_point_test
);

    // Stage 1: doubled center delta, box extents, fallback test
    typedef struct packed {
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
        logic signed [EXT_W-1:0]   wx;
        logic signed [EXT_W-1:0]   wy;
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic                      degen;
        logic                      point_hit;
    } s1_t;

    // Stage 2: all products of extents and deltas with cos/sin
    typedef struct packed {
        logic signed [PROJ_W-1:0]  acsx;
        logic signed [PROJ_W-1:0]  assy;
        logic signed [PROJ_W-1:0]  assx;
        logic signed [PROJ_W-1:0]  acsy;
        logic signed [PROJ_W-1:0]  dxc;
        logic signed [PROJ_W-1:0]  dys;
        logic signed [PROJ_W-1:0]  dyc;
        logic signed [PROJ_W-1:0]  dxs;
        logic signed [PROJ_W-1:0]  wxac;
        logic signed [PROJ_W-1:0]  wyas;
        logic signed [PROJ_W-1:0]  wxas;
        logic signed [PROJ_W-1:0]  wyac;
        logic [DELTA_W-2:0]        abs_dx;
        logic [DELTA_W-2:0]        abs_dy;
        logic signed [EXT_W-1:0]   wx;
        logic signed [EXT_W-1:0]   wy;
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic                      degen;
        logic                      point_hit;
    } s2_t;

    // Stage 3: rectangle-axis projections and radius half sums
    typedef struct packed {
        logic signed [PROJ_W-1:0] rx;
        logic signed [PROJ_W-1:0] ry;
        logic signed [PROJ_W-1:0] pa1;
        logic signed [PROJ_W-1:0] pa2;
        logic signed [PROJ_W-1:0] pb1a;
        logic signed [PROJ_W-1:0] pb1b;
        logic signed [PROJ_W-1:0] pb2a;
        logic signed [PROJ_W-1:0] pb2b;
        logic signed [PROJ_W-1:0] pb3a;
        logic signed [PROJ_W-1:0] pb3b;
        logic signed [PROJ_W-1:0] pb4a;
        logic signed [PROJ_W-1:0] pb4b;
        logic                     degen;
        logic                     point_hit;
    } s3_t;

    // Stage 4: distance and radius on each of the four axes
    typedef struct packed {
        logic signed [PROJ_W-1:0] pa1;
        logic signed [PROJ_W-1:0] pa2;
        logic signed [PROJ_W-1:0] pa3;
        logic signed [PROJ_W-1:0] pa4;
        logic signed [PROJ_W-1:0] pb1;
        logic signed [PROJ_W-1:0] pb2;
        logic signed [PROJ_W-1:0] pb3;
        logic signed [PROJ_W-1:0] pb4;
        logic                     degen;
        logic                     point_hit;
    } s4_t;

    logic [TOL_W-1:0] tol_reg;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic v4_reg;
    logic v5_reg;

    logic ready1;
    logic ready2;
    logic ready3;
    logic ready4;
    logic ready5;

    s1_t  s1_reg;
    s1_t  s1_next;
    s2_t  s2_reg;
    s2_t  s2_next;
    s3_t  s3_reg;
    s3_t  s3_next;
    s4_t  s4_reg;
    s4_t  s4_next;
    logic hit_reg;
    logic hit_next;
    logic used_reg;

    trig_t trig;

    logic signed [DELTA_W-1:0] cx2;
    logic signed [DELTA_W-1:0] cy2;
    logic signed [DELTA_W-1:0] sum_x;
    logic signed [DELTA_W-1:0] sum_y;
    logic signed [DELTA_W-1:0] neg_dx;
    logic signed [DELTA_W-1:0] neg_dy;
    logic signed [TRIG_W:0]    ac_s;
    logic signed [TRIG_W:0]    as_s;
    logic signed [PROJ_W-1:0]  tol_q;
    logic                      sep;

    // Hold tolerance; the user must keep writes to an empty pipeline, unenforced
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= '0;
        else if (cfg_wr_en)
            tol_reg <= cfg_wr_data;
    end

    // A stage takes a word when it is empty or its word moves on
    assign ready5   = !v5_reg || out_ready;
    assign ready4   = !v4_reg || ready5;
    assign ready3   = !v3_reg || ready4;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign in_ready = ready1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
                v1_reg <= in_valid;
            if (ready2)
                v2_reg <= v1_reg;
            if (ready3)
                v3_reg <= v2_reg;
            if (ready4)
                v4_reg <= v3_reg;
            if (ready5)
                v5_reg <= v4_reg;
        end
    end

    // Stage 1 sine/cosine lookup, registered alongside s1_reg
    orbo_trig u_trig (
        .clk   (clk),
        .load  (in_valid && ready1),
        .angle (rect_angle),
        .trig  (trig)
    );

    // Stage 1: doubled center delta keeps the half sizes exact
    always_comb
    begin
        cx2   = DELTA_W'(rect_center_x) <<< 1;
        cy2   = DELTA_W'(rect_center_y) <<< 1;
        sum_x = DELTA_W'(box_min_x) + DELTA_W'(box_max_x);
        sum_y = DELTA_W'(box_min_y) + DELTA_W'(box_max_y);

        s1_next.dx = cx2 - sum_x;
        s1_next.dy = cy2 - sum_y;
        s1_next.wx = EXT_W'(box_max_x) - EXT_W'(box_min_x);
        s1_next.wy = EXT_W'(box_max_y) - EXT_W'(box_min_y);
        s1_next.sx = rect_size_x;
        s1_next.sy = rect_size_y;
        // Zero or negative size in either direction drops to the center point test
        s1_next.degen = rect_size_x[COORD_W-1] || (rect_size_x == '0) ||
                        rect_size_y[COORD_W-1] || (rect_size_y == '0);
        s1_next.point_hit = (rect_center_x >= box_min_x) && (rect_center_x <= box_max_x) &&
                            (rect_center_y >= box_min_y) && (rect_center_y <= box_max_y);
    end

    // Stage 2: one product per field, plus absolute box-axis deltas
    always_comb
    begin
        ac_s   = $signed({1'b0, trig.abs_c});
        as_s   = $signed({1'b0, trig.abs_s});
        neg_dx = -s1_reg.dx;
        neg_dy = -s1_reg.dy;

        s2_next.acsx = s1_reg.sx * ac_s;
        s2_next.assy = s1_reg.sy * as_s;
        s2_next.assx = s1_reg.sx * as_s;
        s2_next.acsy = s1_reg.sy * ac_s;
        s2_next.dxc  = s1_reg.dx * trig.c;
        s2_next.dys  = s1_reg.dy * trig.s;
        s2_next.dyc  = s1_reg.dy * trig.c;
        s2_next.dxs  = s1_reg.dx * trig.s;
        s2_next.wxac = s1_reg.wx * ac_s;
        s2_next.wyas = s1_reg.wy * as_s;
        s2_next.wxas = s1_reg.wx * as_s;
        s2_next.wyac = s1_reg.wy * ac_s;

        s2_next.abs_dx    = s1_reg.dx[DELTA_W-1] ? neg_dx[DELTA_W-2:0] : s1_reg.dx[DELTA_W-2:0];
        s2_next.abs_dy    = s1_reg.dy[DELTA_W-1] ? neg_dy[DELTA_W-2:0] : s1_reg.dy[DELTA_W-2:0];
        s2_next.wx        = s1_reg.wx;
        s2_next.wy        = s1_reg.wy;
        s2_next.sx        = s1_reg.sx;
        s2_next.sy        = s1_reg.sy;
        s2_next.degen     = s1_reg.degen;
        s2_next.point_hit = s1_reg.point_hit;
    end

    // Tolerance in the doubled Q15 scale of the projections
    assign tol_q = PROJ_W'(tol_reg) << TOL_SHIFT;

    // Stage 3: split each four-term radius into two adds
    always_comb
    begin
        s3_next.rx   = s2_reg.dxc + s2_reg.dys;
        s3_next.ry   = s2_reg.dyc - s2_reg.dxs;
        s3_next.pa1  = PROJ_W'(s2_reg.abs_dx) << TRIG_SHIFT;
        s3_next.pa2  = PROJ_W'(s2_reg.abs_dy) << TRIG_SHIFT;
        s3_next.pb1a = (PROJ_W'(s2_reg.wx) <<< TRIG_SHIFT) + s2_reg.acsx;
        s3_next.pb1b = s2_reg.assy + tol_q;
        s3_next.pb2a = (PROJ_W'(s2_reg.wy) <<< TRIG_SHIFT) + s2_reg.assx;
        s3_next.pb2b = s2_reg.acsy + tol_q;
        s3_next.pb3a = s2_reg.wxac + s2_reg.wyas;
        s3_next.pb3b = (PROJ_W'(s2_reg.sx) <<< TRIG_SHIFT) + tol_q;
        s3_next.pb4a = s2_reg.wxas + s2_reg.wyac;
        s3_next.pb4b = (PROJ_W'(s2_reg.sy) <<< TRIG_SHIFT) + tol_q;
        s3_next.degen     = s2_reg.degen;
        s3_next.point_hit = s2_reg.point_hit;
    end

    // Stage 4: finish radii, fold rectangle-axis projections to magnitudes
    always_comb
    begin
        s4_next.pa1 = s3_reg.pa1;
        s4_next.pa2 = s3_reg.pa2;
        s4_next.pa3 = s3_reg.rx[PROJ_W-1] ? -s3_reg.rx : s3_reg.rx;
        s4_next.pa4 = s3_reg.ry[PROJ_W-1] ? -s3_reg.ry : s3_reg.ry;
        s4_next.pb1 = s3_reg.pb1a + s3_reg.pb1b;
        s4_next.pb2 = s3_reg.pb2a + s3_reg.pb2b;
        s4_next.pb3 = s3_reg.pb3a + s3_reg.pb3b;
        s4_next.pb4 = s3_reg.pb4a + s3_reg.pb4b;
        s4_next.degen     = s3_reg.degen;
        s4_next.point_hit = s3_reg.point_hit;
    end

    // Stage 5: any axis with distance beyond radius separates; a touch is a hit
    always_comb
    begin
        sep = (s4_reg.pa1 > s4_reg.pb1) || (s4_reg.pa2 > s4_reg.pb2) ||
              (s4_reg.pa3 > s4_reg.pb3) || (s4_reg.pa4 > s4_reg.pb4);
        hit_next = s4_reg.degen ? s4_reg.point_hit : !sep;
    end

    // Advance payload only where the stage takes a new word
    always_ff @(posedge clk)
    begin
        if (in_valid && ready1)
            s1_reg <= s1_next;
        if (v1_reg && ready2)
            s2_reg <= s2_next;
        if (v2_reg && ready3)
            s3_reg <= s3_next;
        if (v3_reg && ready4)
            s4_reg <= s4_next;
        if (v4_reg && ready5)
        begin
            hit_reg  <= hit_next;
            used_reg <= s4_reg.degen;
        end
    end

    assign out_valid       = v5_reg;
    assign overlap_hit     = hit_reg;
    assign used_point_test = used_reg;

    // An open output never blocks the input
    a_out_ready_opens_input: assert property (
        @(posedge clk) disable iff (!rst_n) out_ready |-> in_ready)
        else $error("input stalled while output was ready");

    // An empty front stage always takes a word
    a_empty_front_ready: assert property (
        @(posedge clk) disable iff (!rst_n) !v1_reg |-> in_ready)
        else $error("input stalled with empty front stage");

    // A taken word lands in the front stage
    a_accept_lands: assert property (
        @(posedge clk) disable iff (!rst_n) (in_valid && in_ready) |=> v1_reg)
        else $error("accepted word lost at front stage");

    // A word moving out of stage 4 shows up as a result
    a_last_stage_delivers: assert property (
        @(posedge clk) disable iff (!rst_n) (v4_reg && ready5) |=> out_valid)
        else $error("word lost between last stage and output");

endmodule

FILE: test/testbench.sv
typedef struct packed {
    logic signed [orbo_pkg::COORD_W-1:0] center_x;
    logic signed [orbo_pkg::COORD_W-1:0] center_y;
    logic signed [orbo_pkg::COORD_W-1:0] size_x;
    logic signed [orbo_pkg::COORD_W-1:0] size_y;
    logic [orbo_pkg::ANGLE_W-1:0]        angle;
    logic signed [orbo_pkg::COORD_W-1:0] min_x;
    logic signed [orbo_pkg::COORD_W-1:0] min_y;
    logic signed [orbo_pkg::COORD_W-1:0] max_x;
    logic signed [orbo_pkg::COORD_W-1:0] max_y;
} rect_word_t;

typedef struct packed {
    logic hit;
    logic point;
} overlap_result_t;

localparam longint unsigned HALF_PI_Q30  = 64'd1686629713;
localparam longint          Q30_UNIT     = 64'sd1073741824;
localparam longint          Q15_UNIT     = 64'sd32768;
localparam longint          ROUND_HALF   = 64'sd16384;
localparam longint          SLACK_SCALE  = 64'sd65536;
localparam int              TAYLOR_ORDER = 8;

class overlap_scoreboard;
    logic [orbo_pkg::TOL_W-1:0] tolerance;
    overlap_result_t            awaited_hits[$];
    int                         mismatches;
    int                         words;
    int                         hits;
    int                         point_tests;

    function new();
        tolerance   = '0;
        mismatches  = 0;
        words       = 0;
        hits        = 0;
        point_tests = 0;
    endfunction

    function longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // sine over a quarter turn in Q15, frac counts ANGLE_STEPS per quarter
    function longint quarter_wave(longint unsigned frac);
        longint unsigned arg;
        longint unsigned arg_sq;
        longint unsigned piece;
        longint          acc;
        longint          q15;
        int              n;
        arg    = (HALF_PI_Q30 * frac) / orbo_pkg::ANGLE_STEPS;
        arg_sq = (arg * arg) >> 30;
        piece  = arg;
        acc    = longint'(arg);
        for (n = 1; n <= TAYLOR_ORDER; n++)
        begin
            piece = (piece * arg_sq) >> 30;
            piece = piece / (2 * n * (2 * n + 1));
            if (n % 2 == 1)
                acc = acc - longint'(piece);
            else
                acc = acc + longint'(piece);
        end
        if (acc < 0)
            acc = 0;
        if (acc > Q30_UNIT)
            acc = Q30_UNIT;
        q15 = (acc + ROUND_HALF) >>> 15;
        if (q15 > Q15_UNIT)
            q15 = Q15_UNIT;
        return q15;
    endfunction

    // work out the hit for one word and queue it
    function void predict_overlap(rect_word_t w);
        longint          cx, cy, sx, sy, mnx, mny, mxx, mxy;
        longint          ms, mc, c, s, abs_c, abs_s;
        longint          dx, dy, wx, wy, slack;
        longint unsigned turn4, quadrant, rem;
        overlap_result_t r;
        bit              apart;
        cx  = w.center_x;
        cy  = w.center_y;
        sx  = w.size_x;
        sy  = w.size_y;
        mnx = w.min_x;
        mny = w.min_y;
        mxx = w.max_x;
        mxy = w.max_y;
        words++;
        if (sx <= 0 || sy <= 0)
        begin
            r.hit   = (cx >= mnx && cx <= mxx && cy >= mny && cy <= mxy);
            r.point = 1'b1;
        end
        else
        begin
            turn4    = longint'(w.angle) * 4;
            quadrant = turn4 / orbo_pkg::ANGLE_STEPS;
            rem      = turn4 - quadrant * orbo_pkg::ANGLE_STEPS;
            ms       = quarter_wave(rem);
            mc       = quarter_wave(orbo_pkg::ANGLE_STEPS - rem);
            case (quadrant % 4)
                0:       begin c = mc;  s = ms;  end
                1:       begin c = -ms; s = mc;  end
                2:       begin c = -mc; s = -ms; end
                default: begin c = ms;  s = -mc; end
            endcase
            abs_c = magnitude(c);
            abs_s = magnitude(s);
            dx    = 2 * cx - (mnx + mxx);
            dy    = 2 * cy - (mny + mxy);
            wx    = mxx - mnx;
            wy    = mxy - mny;
            slack = longint'(tolerance) * SLACK_SCALE;
            apart = magnitude(dx) * Q15_UNIT > wx * Q15_UNIT + abs_c * sx + abs_s * sy + slack;
            apart |= magnitude(dy) * Q15_UNIT > wy * Q15_UNIT + abs_s * sx + abs_c * sy + slack;
            apart |= magnitude(dx * c + dy * s) > wx * abs_c + wy * abs_s + sx * Q15_UNIT + slack;
            apart |= magnitude(dy * c - dx * s) > wx * abs_s + wy * abs_c + sy * Q15_UNIT + slack;
            r.hit   = !apart;
            r.point = 1'b0;
        end
        if (r.hit)
            hits++;
        if (r.point)
            point_tests++;
        awaited_hits.push_back(r);
    endfunction

    function void check_result(logic hit, logic point);
        overlap_result_t r;
        if (awaited_hits.size() == 0)
        begin
            $display("%0t: result with nothing expected: hit=%b point=%b", $time, hit, point);
            mismatches++;
            return;
        end
        r = awaited_hits.pop_front();
        if (hit !== r.hit)
        begin
            $display("%0t: overlap_hit expected %b actual %b", $time, r.hit, hit);
            mismatches++;
        end
        if (point !== r.point)
        begin
            $display("%0t: used_point_test expected %b actual %b", $time, r.point, point);
            mismatches++;
        end
    endfunction

    function int pending();
        return awaited_hits.size();
    endfunction
endclass

module testbench;
    import orbo_pkg::*;

    // Five pipeline stages; SETTLE_CYCLES of slack follow the drain before any idle action
    localparam int SETTLE_CYCLES = 10;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_WORDS   = 90;
    localparam int COORD_MAX     = 8388607;
    localparam int COORD_MIN     = -8388608;

    logic                      clk             = 1'b0;
    logic                      rst_n           = 1'b0;
    logic                      cfg_wr_en       = 1'b0;
    logic [TOL_W-1:0]          cfg_wr_data     = '0;
    logic                      in_valid        = 1'b0;
    logic                      in_ready;
    logic signed [COORD_W-1:0] rect_center_x   = '0;
    logic signed [COORD_W-1:0] rect_center_y   = '0;
    logic signed [COORD_W-1:0] rect_size_x     = '0;
    logic signed [COORD_W-1:0] rect_size_y     = '0;
    logic [ANGLE_W-1:0]        rect_angle      = '0;
    logic signed [COORD_W-1:0] box_min_x       = '0;
    logic signed [COORD_W-1:0] box_min_y       = '0;
    logic signed [COORD_W-1:0] box_max_x       = '0;
    logic signed [COORD_W-1:0] box_max_y       = '0;
    logic                      out_valid;
    logic                      out_ready       = 1'b0;
    logic                      overlap_hit;
    logic                      used_point_test;

    overlap_scoreboard overlap_check = new();

    int cycle_count   = 0;
    int settings_used = 0;
    // Idle cycles owed before the next word; zero after a send means in_valid stays up
    int gap_owed      = 0;
    // When set, neither side idles: back-to-back words and an always-ready sink
    bit calm          = 1'b0;

    oriented_rect_box_overlap i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rect_center_x   (rect_center_x),
        .rect_center_y   (rect_center_y),
        .rect_size_x     (rect_size_x),
        .rect_size_y     (rect_size_y),
        .rect_angle      (rect_angle),
        .box_min_x       (box_min_x),
        .box_min_y       (box_min_y),
        .box_max_x       (box_max_x),
        .box_max_y       (box_max_y),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .overlap_hit     (overlap_hit),
        .used_point_test (used_point_test)
    );

    initial
    begin
        forever
            #4 clk = ~clk;
    end

    // Hard stop in case the block hangs on either handshake
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    // Check every result word taken at an edge against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
            overlap_check.check_result(overlap_hit, used_point_test);
    end

    // Draw a wait, weighted toward none; no waits in calm stretches
    function automatic int draw_wait();
        if (calm || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 12);
    endfunction

    function automatic logic signed [COORD_W-1:0] to_coord(int v);
        return COORD_W'(v);
    endfunction

    function automatic rect_word_t make_word(int cx, int cy, int sx, int sy, int ang,
                                             int mnx, int mny, int mxx, int mxy);
        rect_word_t w;
        w.center_x = to_coord(cx);
        w.center_y = to_coord(cy);
        w.size_x   = to_coord(sx);
        w.size_y   = to_coord(sy);
        w.angle    = ANGLE_W'(ang);
        w.min_x    = to_coord(mnx);
        w.min_y    = to_coord(mny);
        w.max_x    = to_coord(mxx);
        w.max_y    = to_coord(mxy);
        return w;
    endfunction

    // Random geometry: mostly a rectangle placed near a box at a random scale,
    // with edge-touch cases, degenerate sizes, inverted boxes and raw noise mixed in
    function automatic rect_word_t random_word();
        rect_word_t w;
        int         pick, span, bx, by, bw, bh, sx, sy, cx, cy, off, hx, quarter, bad;
        pick = $urandom_range(0, 99);
        span = 1 << $urandom_range(2, 20);
        bx   = int'($urandom_range(0, 8 * span)) - 4 * span;
        by   = int'($urandom_range(0, 8 * span)) - 4 * span;
        bw   = $urandom_range(0, span);
        bh   = $urandom_range(0, span);
        sx   = $urandom_range(1, span);
        sy   = $urandom_range(1, span);
        cx   = bx + bw / 2 + int'($urandom_range(0, 4 * span)) - 2 * span;
        cy   = by + bh / 2 + int'($urandom_range(0, 4 * span)) - 2 * span;
        if (pick < 55)
        begin
            w = make_word(cx, cy, sx, sy, $urandom_range(0, ANGLE_STEPS - 1),
                          bx, by, bx + bw, by + bh);
        end
        else if (pick < 67)
        begin
            // Axis-aligned rectangle set against the left or right box edge,
            // within 3 LSBs either way or 10 in to 200 out, so the tolerance decides
            quarter = $urandom_range(0, 3);
            sx      = 2 * int'($urandom_range(1, span / 2));
            sy      = 2 * int'($urandom_range(1, span / 2));
            hx      = (quarter % 2 == 1) ? sy / 2 : sx / 2;
            if ($urandom_range(0, 1) == 1)
                off = int'($urandom_range(0, 6)) - 3;
            else
                off = int'($urandom_range(0, 210)) - 10;
            if ($urandom_range(0, 1) == 1)
                cx = bx + bw + hx + off;
            else
                cx = bx - hx - off;
            cy = by + int'($urandom_range(0, bh));
            w  = make_word(cx, cy, sx, sy, quarter * QTR_STEPS, bx, by, bx + bw, by + bh);
        end
        else if (pick < 80)
        begin
            // Zero or negative size; put the center on a box edge, one LSB either way
            case ($urandom_range(0, 2))
                0:       bad = 0;
                1:       bad = -int'($urandom_range(1, span));
                default: bad = COORD_MIN;
            endcase
            case ($urandom_range(0, 2))
                0:       sx = bad;
                1:       sy = bad;
                default: begin sx = bad; sy = -int'($urandom_range(0, span)); end
            endcase
            cx = ($urandom_range(0, 1) == 1 ? bx : bx + bw) + int'($urandom_range(0, 2)) - 1;
            if ($urandom_range(0, 1) == 1)
                cy = ($urandom_range(0, 1) == 1 ? by : by + bh) + int'($urandom_range(0, 2)) - 1;
            else
                cy = by + int'($urandom_range(0, bh));
            w = make_word(cx, cy, sx, sy, $urandom_range(0, ANGLE_STEPS - 1),
                          bx, by, bx + bw, by + bh);
        end
        else if (pick < 88)
        begin
            // Inverted box: min above max, either test path
            if ($urandom_range(0, 2) == 0)
                sx = -int'($urandom_range(0, span));
            w = make_word(cx, cy, sx, sy, $urandom_range(0, ANGLE_STEPS - 1),
                          bx + bw + 1, by + bh + 1, bx, by);
        end
        else
        begin
            w.center_x = COORD_W'($urandom());
            w.center_y = COORD_W'($urandom());
            w.size_x   = COORD_W'($urandom());
            w.size_y   = COORD_W'($urandom());
            w.angle    = ANGLE_W'($urandom());
            w.min_x    = COORD_W'($urandom());
            w.min_y    = COORD_W'($urandom());
            w.max_x    = COORD_W'($urandom());
            w.max_y    = COORD_W'($urandom());
        end
        return w;
    endfunction

    // Hold one word on the input until taken, then decide the next gap:
    // drop in_valid now if there is one, otherwise leave it up for the next word
    task automatic send_word(input rect_word_t w);
        if (gap_owed > 0)
            repeat (gap_owed) @(posedge clk);
        rect_center_x <= w.center_x;
        rect_center_y <= w.center_y;
        rect_size_x   <= w.size_x;
        rect_size_y   <= w.size_y;
        rect_angle    <= w.angle;
        box_min_x     <= w.min_x;
        box_min_y     <= w.min_y;
        box_max_x     <= w.max_x;
        box_max_y     <= w.max_y;
        in_valid      <= 1'b1;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        overlap_check.predict_overlap(w);
        gap_owed = draw_wait();
        if (gap_owed > 0)
            in_valid <= 1'b0;
    endtask

    // Drop the input and wait until every predicted result has come back
    task automatic drain_results();
        if (gap_owed == 0)
            in_valid <= 1'b0;
        gap_owed = 0;
        while (overlap_check.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_tolerance(input logic [TOL_W-1:0] value);
        drain_results();
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        overlap_check.tolerance = value;
        settings_used++;
    endtask

    // Result side: stall a random number of cycles before each result word
    initial
    begin : receiver
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = draw_wait();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
        end
    end

    initial
    begin : stimulus
        int phase;
        int i;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at the reset tolerance of zero.
        // Plain overlap, exact edge touch, and one LSB past it.
        send_word(make_word(128, 128, 256, 256, 0, 0, 0, 256, 256));
        send_word(make_word(384, 128, 256, 256, 0, 0, 0, 256, 256));
        send_word(make_word(385, 128, 256, 256, 0, 0, 0, 256, 256));
        // Quarter turn swaps the extents, so both words still overlap.
        send_word(make_word(384, 128, 256, 512, QTR_STEPS, 0, 0, 256, 256));
        send_word(make_word(385, 128, 256, 512, QTR_STEPS, 0, 0, 256, 256));
        // Diagonal square near a corner, half and three-quarter turns, last step.
        send_word(make_word(440, 440, 256, 256, QTR_STEPS / 2, 0, 0, 256, 256));
        send_word(make_word(-130, 128, 256, 100, 2 * QTR_STEPS, 0, 0, 256, 256));
        send_word(make_word(128, 310, 100, 256, 3 * QTR_STEPS, 0, 0, 256, 256));
        send_word(make_word(-120, -120, 256, 256, ANGLE_STEPS - 1, 0, 0, 256, 256));
        // Extremes of the coordinate range.
        send_word(make_word(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX, ANGLE_STEPS - 1,
                            COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
        send_word(make_word(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0,
                            COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
        send_word(make_word(COORD_MIN, COORD_MIN, 1, 1, 1,
                            COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
        // Point test: on the min corner, below it, on the max corner, above it.
        send_word(make_word(-50, -50, 0, 5, 300, -50, -50, 70, 70));
        send_word(make_word(-51, -50, 0, 5, 300, -50, -50, 70, 70));
        send_word(make_word(70, 70, 7, -1, 300, -50, -50, 70, 70));
        send_word(make_word(70, 71, 7, -1, 300, -50, -50, 70, 70));
        send_word(make_word(10, 10, COORD_MIN, 100, 0, -50, -50, 70, 70));
        // Inverted box on both paths.
        send_word(make_word(10, 10, 0, 0, 0, 70, 70, -50, -50));
        send_word(make_word(10, 10, 40, 40, 0, 70, 70, -50, -50));

        // Smallest tolerance turns the one-LSB miss into a hit, the next one stays out.
        set_tolerance(TOL_W'(1));
        send_word(make_word(385, 128, 256, 256, 0, 0, 0, 256, 256));
        send_word(make_word(386, 128, 256, 256, 0, 0, 0, 256, 256));
        send_word(make_word(128, 386, 256, 256, 2 * QTR_STEPS, 0, 0, 256, 256));

        // Random phases, each at its own tolerance, extremes first
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       set_tolerance('1);
                1:       set_tolerance('0);
                default: set_tolerance(TOL_W'($urandom_range(2, 254)));
            endcase
            for (i = 0; i < PHASE_WORDS; i++)
            begin
                if (i % 30 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                // Now and then let the pipeline run dry mid-phase
                if ($urandom_range(0, 59) == 0)
                    drain_results();
                send_word(random_word());
            end
        end
        calm = 1'b0;

        drain_results();
        $display("summary: %0d words checked, %0d hits, %0d point tests",
                 overlap_check.words, overlap_check.hits, overlap_check.point_tests);
        $display("summary: %0d tolerance settings, %0d mismatches",
                 settings_used, overlap_check.mismatches);
        if (overlap_check.mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
